// ----- design/rtbo_pkg.sv -----
// ----------------------------------------------------------------------------
// rtbo_pkg
// types and constants for the retry table
// ----------------------------------------------------------------------------
package rtbo_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned TimeW      = 48;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic [1:0] OpEnqueue = 2'd0;
  localparam logic [1:0] OpReport  = 2'd1;
  localparam logic [1:0] OpDueScan = 2'd2;
  localparam logic [1:0] OpSweep   = 2'd3;

  localparam logic [3:0] StQueued    = 4'd0;
  localparam logic [3:0] StDuplicate = 4'd1;
  localparam logic [3:0] StFull      = 4'd2;
  localparam logic [3:0] StNotFound  = 4'd3;
  localparam logic [3:0] StSucceeded = 4'd4;
  localparam logic [3:0] StExhausted = 4'd5;
  localparam logic [3:0] StResched   = 4'd6;
  localparam logic [3:0] StDue       = 4'd7;
  localparam logic [3:0] StNoneDue   = 4'd8;
  localparam logic [3:0] StSwept     = 4'd9;

  localparam logic [1:0] RegTtl      = 2'd0;
  localparam logic [1:0] RegCapacity = 2'd1;
  localparam logic [1:0] RegRetry    = 2'd2;
  localparam logic [1:0] RegBackoff  = 2'd3;

  typedef struct packed {
    logic [1:0]      operation;
    logic [KeyW-1:0] assoc_key;
    logic [63:0]     version_tag;
    logic            success;
    logic [47:0]     now_time;
  } req_t;

  typedef struct packed {
    logic [3:0]      status;
    logic [31:0]     out_assoc_key;
    logic [63:0]     out_version;
    logic [4:0]      removed_count;
    logic            last;
  } rsp_t;

  // identity part of a slot, written on enqueue only
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [63:0]      version;
    logic [TimeW-1:0] created_at;
  } slot_id_t;

  // schedule part of a slot, written on enqueue and reschedule
  typedef struct packed {
    logic [4:0]       attempts;
    logic [TimeW-1:0] eligible_at;
  } slot_sched_t;

endpackage

// ----- design/retry_table_exponential_backoff.sv -----
// ----------------------------------------------------------------------------
// retry_table_exponential_backoff
// table of pending retries with exponential backoff, due scan and ttl sweep
// ----------------------------------------------------------------------------
// Each request beat walks the whole table: the slot contents sit in two
// synchronous memories (identity and schedule) with registered read data;
// one slot is read per cycle while the response register can take a beat,
// and checked once its read data is registered; a decide step follows the
// walk. The final response beat shows when the block is idle again, and the
// next request beat can be accepted in that same cycle, so the block takes
// no new request before the last one is through. req stall is high from
// the accepting edge until the block is idle again. Due scan holds each due
// slot back by one so the last one can carry the last flag; a held beat goes
// out when the next due slot is found. The walk and the decide cycle freeze
// while the response register holds a beat under rsp stall. Valid bits live
// in flip-flops so reset empties the table at once; no clearing pass.
// Configuration is taken only while the block is idle.
module retry_table_exponential_backoff (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid,
  output logic             req_stall,
  input  rtbo_pkg::req_t   req_data_i,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rtbo_pkg::rsp_t   rsp_data_o,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int unsigned SW = rtbo_pkg::SlotW;
  localparam int unsigned CW = rtbo_pkg::CntW;
  localparam int unsigned TW = rtbo_pkg::TimeW;

  // state codes
  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SWalk   = 2'd1;  // issue reads, check returned slot
  localparam logic [1:0] SDecide = 2'd2;  // act on the walk result

  logic [1:0] state_q, state_d;

  // configuration
  logic [31:0] ttl_q;
  logic [4:0]  cap_q, retry_q;
  logic [19:0] backoff_q;

  assign cfg_ready = (state_q == SIdle);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q     <= 32'd60000;
      cap_q     <= 5'd16;
      retry_q   <= 5'd3;
      backoff_q <= 20'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_i)
        rtbo_pkg::RegTtl:      ttl_q     <= cfg_data_i;
        rtbo_pkg::RegCapacity: cap_q     <= cfg_data_i[4:0];
        rtbo_pkg::RegRetry:    retry_q   <= cfg_data_i[4:0];
        rtbo_pkg::RegBackoff:  backoff_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // slot memories
  rtbo_pkg::slot_id_t    id_mem  [rtbo_pkg::TableDepth];
  rtbo_pkg::slot_sched_t sch_mem [rtbo_pkg::TableDepth];
  rtbo_pkg::slot_id_t    id_rd_q;
  rtbo_pkg::slot_sched_t sch_rd_q;
  logic                  re, id_we, sch_we;
  logic [SW-1:0]         raddr, waddr;
  rtbo_pkg::slot_id_t    id_wdata;
  rtbo_pkg::slot_sched_t sch_wdata;

  always_ff @(posedge clk_i) begin
    if (id_we) id_mem[waddr] <= id_wdata;
    if (sch_we) sch_mem[waddr] <= sch_wdata;
    if (re) begin
      id_rd_q  <= id_mem[raddr];
      sch_rd_q <= sch_mem[raddr];
    end
  end

  logic [rtbo_pkg::TableDepth-1:0] valid_q, valid_d;

  // walk bookkeeping
  rtbo_pkg::req_t      req_q;
  logic [CW-1:0]       ridx_q, ridx_d;   // next read address
  logic                rv_q, rv_d;       // read data holds slot chk_q
  logic [SW-1:0]       chk_q, chk_d;
  logic                hit_q, hit_d;
  logic [SW-1:0]       hslot_q, hslot_d;
  logic [4:0]          hatt_q, hatt_d;
  logic                free_q, free_d;
  logic [SW-1:0]       fslot_q, fslot_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [4:0]          rem_q, rem_d;
  // due slot held back by one beat
  logic                hold_v_q, hold_v_d;
  logic [rtbo_pkg::KeyW-1:0] hold_key_q, hold_key_d;
  logic [63:0]         hold_ver_q, hold_ver_d;

  // response register
  logic           ov_q, ov_d;
  rtbo_pkg::rsp_t rsp_q, rsp_d;
  assign rsp_valid  = ov_q;
  assign rsp_data_o = rsp_q;
  assign req_stall  = (state_q != SIdle);
  assign raddr      = ridx_q[SW-1:0];

  // checks on the returned slot
  logic           cur_v, key_eq, due, old;
  logic [TW-1:0]  age;
  always_comb begin
    cur_v  = rv_q && valid_q[chk_q];
    key_eq = (id_rd_q.key == req_q.assoc_key) && (id_rd_q.version == req_q.version_tag);
    due    = sch_rd_q.eligible_at <= req_q.now_time;
    age    = req_q.now_time - id_rd_q.created_at;
    old    = (req_q.now_time > id_rd_q.created_at) && (age > {16'd0, ttl_q});
  end

  // backoff arithmetic for the decide stage, saturating at the time range
  logic [4:0]    att_n;
  logic [51:0]   sum_e, sum_r;
  logic [50:0]   shifted;
  logic [TW-1:0] elig_e, elig_r;
  always_comb begin
    att_n   = (hatt_q < 5'd31) ? hatt_q + 5'd1 : hatt_q;
    sum_e   = {4'd0, req_q.now_time} + {32'd0, backoff_q};
    shifted = {31'd0, backoff_q} << att_n;
    sum_r   = {4'd0, req_q.now_time} + {1'b0, shifted};
    elig_e  = (sum_e > {4'd0, rtbo_pkg::TimeMax}) ? rtbo_pkg::TimeMax : sum_e[TW-1:0];
    elig_r  = (sum_r > {4'd0, rtbo_pkg::TimeMax}) ? rtbo_pkg::TimeMax : sum_r[TW-1:0];
  end

  // capacity above the table depth acts as the depth
  logic [CW-1:0] cap_eff;
  assign cap_eff = (cap_q > CW'(rtbo_pkg::TableDepth)) ? CW'(rtbo_pkg::TableDepth) : cap_q;

  logic out_free;
  assign out_free = !ov_q || !rsp_stall;  // response register can take a beat

  always_comb begin
    state_d = state_q;  ridx_d = ridx_q;  rv_d = rv_q;  chk_d = chk_q;
    hit_d = hit_q;  hslot_d = hslot_q;  hatt_d = hatt_q;  free_d = free_q;
    fslot_d = fslot_q;  cnt_d = cnt_q;  rem_d = rem_q;  hold_v_d = hold_v_q;
    hold_key_d = hold_key_q;  hold_ver_d = hold_ver_q;  valid_d = valid_q;
    ov_d = ov_q && rsp_stall;  rsp_d = rsp_q;
    re = 1'b0;  id_we = 1'b0;  sch_we = 1'b0;  waddr = fslot_q;
    id_wdata  = '{req_q.assoc_key, req_q.version_tag, req_q.now_time};
    sch_wdata = '{5'd0, elig_e};
    unique case (state_q)
      SIdle: begin
        ridx_d = '0;  rv_d = 1'b0;  hit_d = 1'b0;  free_d = 1'b0;  cnt_d = '0;
        rem_d = '0;  hold_v_d = 1'b0;
        if (req_valid) state_d = SWalk;
      end
      SWalk: begin
        if (out_free) begin
          if (cur_v) begin
            cnt_d = cnt_q + CW'(1);
            if (key_eq && !hit_q) begin
              hit_d = 1'b1;  hslot_d = chk_q;  hatt_d = sch_rd_q.attempts;
            end
            if (req_q.operation == rtbo_pkg::OpDueScan && due) begin
              // the held due beat is not the last one: send it on
              if (hold_v_q) begin
                ov_d = 1'b1;
                rsp_d = '{rtbo_pkg::StDue, 32'(hold_key_q), hold_ver_q, 5'd0, 1'b0};
              end
              hold_v_d = 1'b1;  hold_key_d = id_rd_q.key;  hold_ver_d = id_rd_q.version;
            end
            if (req_q.operation == rtbo_pkg::OpSweep && old) begin
              valid_d[chk_q] = 1'b0;
              rem_d = rem_q + 5'd1;
            end
          end else if (rv_q && !free_q) begin
            free_d = 1'b1;  fslot_d = chk_q;
          end
          if (ridx_q < CW'(rtbo_pkg::TableDepth)) begin
            re = 1'b1;  rv_d = 1'b1;  chk_d = ridx_q[SW-1:0];
            ridx_d = ridx_q + CW'(1);
          end else begin
            rv_d = 1'b0;
            state_d = SDecide;
          end
        end
      end
      SDecide: begin
        if (out_free) begin
          state_d = SIdle;
          ov_d = 1'b1;
          rsp_d = '{rtbo_pkg::StQueued, 32'(req_q.assoc_key), req_q.version_tag,
                    5'd0, 1'b1};
          unique case (req_q.operation)
            rtbo_pkg::OpEnqueue: begin
              if (hit_q) rsp_d.status = rtbo_pkg::StDuplicate;
              else if (cnt_q >= cap_eff || !free_q) rsp_d.status = rtbo_pkg::StFull;
              else begin
                // new entry takes the lowest free slot
                id_we = 1'b1;
                sch_we = 1'b1;
                waddr = fslot_q;
                valid_d[fslot_q] = 1'b1;
              end
            end
            rtbo_pkg::OpReport: begin
              if (!hit_q) rsp_d.status = rtbo_pkg::StNotFound;
              else if (req_q.success) begin
                rsp_d.status = rtbo_pkg::StSucceeded;
                valid_d[hslot_q] = 1'b0;
              end else if (att_n >= retry_q) begin
                rsp_d.status = rtbo_pkg::StExhausted;
                valid_d[hslot_q] = 1'b0;
              end else begin
                rsp_d.status = rtbo_pkg::StResched;
                sch_we = 1'b1;
                waddr = hslot_q;
                sch_wdata = '{att_n, elig_r};
              end
            end
            rtbo_pkg::OpDueScan: begin
              if (hold_v_q)
                rsp_d = '{rtbo_pkg::StDue, 32'(hold_key_q), hold_ver_q, 5'd0, 1'b1};
              else rsp_d.status = rtbo_pkg::StNoneDue;
            end
            default: begin
              rsp_d.status = rtbo_pkg::StSwept;
              rsp_d.removed_count = rem_q;
            end
          endcase
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;  valid_q <= '0;  rv_q <= 1'b0;  ov_q <= 1'b0;
      ridx_q <= '0;  hit_q <= 1'b0;  free_q <= 1'b0;  cnt_q <= '0;
      rem_q <= '0;  hold_v_q <= 1'b0;
    end else begin
      state_q <= state_d;  valid_q <= valid_d;  rv_q <= rv_d;  ov_q <= ov_d;
      ridx_q <= ridx_d;  hit_q <= hit_d;  free_q <= free_d;  cnt_q <= cnt_d;
      rem_q <= rem_d;  hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && req_valid) req_q <= req_data_i;
    chk_q <= chk_d;  hslot_q <= hslot_d;  hatt_q <= hatt_d;  fslot_q <= fslot_d;
    hold_key_q <= hold_key_d;  hold_ver_q <= hold_ver_d;  rsp_q <= rsp_d;
  end

endmodule
